// File: sv/u8sv_pkg.sv
// Package: error codes and byte range constants for the UTF-8 stream validator.
`default_nettype none

package u8sv_pkg;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_BAD_LEAD  = 3'd1,
		ERR_BAD_CONT  = 3'd2,
		ERR_ZERO      = 3'd3,
		ERR_TRUNCATED = 3'd4
	} err_kind_t;

	localparam logic [7:0] CONT_LOW       = 8'h80;
	localparam logic [7:0] CONT_HIGH      = 8'hBF;
	localparam logic [7:0] ASCII_HIGH     = 8'h7F;
	localparam logic [7:0] LEAD2_LOW      = 8'hC2;
	localparam logic [7:0] LEAD2_HIGH     = 8'hDF;
	localparam logic [7:0] LEAD_E0        = 8'hE0;
	localparam logic [7:0] LEAD3_LOW      = 8'hE1;
	localparam logic [7:0] LEAD3_MID_HIGH = 8'hEC;
	localparam logic [7:0] LEAD_ED        = 8'hED;
	localparam logic [7:0] LEAD3_HIGH     = 8'hEF;
	localparam logic [7:0] LEAD_F0        = 8'hF0;
	localparam logic [7:0] LEAD4_LOW      = 8'hF1;
	localparam logic [7:0] LEAD4_HIGH     = 8'hF3;
	localparam logic [7:0] LEAD_F4        = 8'hF4;
	localparam logic [7:0] E0_CONT_LOW    = 8'hA0;
	localparam logic [7:0] ED_CONT_HIGH   = 8'h9F;
	localparam logic [7:0] F0_CONT_LOW    = 8'h90;
	localparam logic [7:0] F4_CONT_HIGH   = 8'h8F;

endpackage

`default_nettype wire

// File: sv/utf8_stream_validator_unit.sv
// Top level: strict streaming UTF-8 checker, one byte per request.
`default_nettype none

//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------------
//  in       | into unit | in_valid/in_stall  | data_byte[7:0], last_byte
//  out      | out       | out_valid/out_stall| byte_ok, error_kind[2:0], text_done, text_valid
//
//  One byte per clock cycle sustained while out_stall is low; the result becomes valid once the
//  byte has passed the input register and then the result register.
//  The throughput is set by the update of the sequence state
//  (continuations owed, next range, sticky error) from the byte held in the input register.
//  arst_n clears the valid flags and the sequence state at once.
//  A stall on the output holds the result and, once the input register is full, the input.

module utf8_stream_validator_unit
	import u8sv_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            byte_ok,
	output logic [2:0]      error_kind,
	output logic            text_done,
	output logic            text_valid
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// result register
	logic       valid_s2;
	logic       ok_s2;
	err_kind_t  kind_s2;
	logic       done_s2;
	logic       text_ok_s2;

	// sequence state
	logic [1:0] cont_left_q;
	logic [7:0] low_q;
	logic [7:0] high_q;
	logic       err_seen_q;

	logic       load_s2;
	logic       load_s1;

	logic [1:0] cont_left_d;
	logic [7:0] low_d;
	logic [7:0] high_d;
	logic       err_seen_d;
	err_kind_t  kind_d;
	logic       ok_d;
	logic       text_ok_d;

	// Advance the result register whenever it is empty or being taken; the input
	// register follows into it, so a request can enter every cycle while out_stall is low.
	assign load_s2  = valid_s1 && (!valid_s2 || !out_stall);
	assign load_s1  = in_valid && !in_stall;
	assign in_stall = valid_s1 && !load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Check the held byte against the sequence state.
	always_comb begin
		cont_left_d = cont_left_q;
		low_d       = low_q;
		high_d      = high_q;
		err_seen_d  = err_seen_q;
		kind_d      = ERR_NONE;

		if (!err_seen_q) begin
			if (cont_left_q != 2'd0) begin
				// a continuation byte is owed: it must sit inside the current range
				if (byte_s1 < low_q || byte_s1 > high_q) begin
					kind_d = ERR_BAD_CONT;
				end else begin
					cont_left_d = cont_left_q - 2'd1;
					low_d       = CONT_LOW;
					high_d      = CONT_HIGH;
				end
			end else begin
				// a lead byte is expected; narrow the first continuation's range
				// for the leads that would otherwise allow overlong forms,
				// surrogates or code points past the top of the range
				priority if (byte_s1 == 8'h00) begin
					kind_d = ERR_ZERO;
				end else if (byte_s1 <= ASCII_HIGH) begin
					kind_d = ERR_NONE;
				end else if (byte_s1 >= LEAD2_LOW && byte_s1 <= LEAD2_HIGH) begin
					cont_left_d = 2'd1;
				end else if (byte_s1 == LEAD_E0) begin
					cont_left_d = 2'd2;
					low_d       = E0_CONT_LOW;
				end else if ((byte_s1 >= LEAD3_LOW && byte_s1 <= LEAD3_MID_HIGH)
						|| (byte_s1 > LEAD_ED && byte_s1 <= LEAD3_HIGH)) begin
					cont_left_d = 2'd2;
				end else if (byte_s1 == LEAD_ED) begin
					cont_left_d = 2'd2;
					high_d      = ED_CONT_HIGH;
				end else if (byte_s1 == LEAD_F0) begin
					cont_left_d = 2'd3;
					low_d       = F0_CONT_LOW;
				end else if (byte_s1 >= LEAD4_LOW && byte_s1 <= LEAD4_HIGH) begin
					cont_left_d = 2'd3;
				end else if (byte_s1 == LEAD_F4) begin
					cont_left_d = 2'd3;
					high_d      = F4_CONT_HIGH;
				end else begin
					kind_d = ERR_BAD_LEAD;
				end
			end

			// last byte leaves a sequence open: the text is truncated
			if (kind_d == ERR_NONE && last_s1 && cont_left_d != 2'd0) begin
				kind_d = ERR_TRUNCATED;
			end
			if (kind_d != ERR_NONE) begin
				err_seen_d = 1'b1;
			end
		end

		ok_d      = !err_seen_q && (kind_d == ERR_NONE);
		text_ok_d = last_s1 && !err_seen_d;
	end

	// Update the sequence state as the byte moves into the result register;
	// drop everything back to reset at the end of a text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_left_q <= 2'd0;
			low_q       <= CONT_LOW;
			high_q      <= CONT_HIGH;
			err_seen_q  <= 1'b0;
		end else if (load_s2) begin
			if (last_s1) begin
				cont_left_q <= 2'd0;
				low_q       <= CONT_LOW;
				high_q      <= CONT_HIGH;
				err_seen_q  <= 1'b0;
			end else begin
				cont_left_q <= cont_left_d;
				low_q       <= low_d;
				high_q      <= high_d;
				err_seen_q  <= err_seen_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			ok_s2      <= ok_d;
			kind_s2    <= kind_d;
			done_s2    <= last_s1;
			text_ok_s2 <= text_ok_d;
		end
	end

	assign out_valid  = valid_s2;
	assign byte_ok    = ok_s2;
	assign error_kind = kind_s2;
	assign text_done  = done_s2;
	assign text_valid = text_ok_s2;

endmodule

`default_nettype wire

// File: sv/u8sv_checker.sv
// Checker: port-level assertions for the UTF-8 stream validator, and its bind.
`default_nettype none

module u8sv_checker
	import u8sv_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       byte_ok,
	input wire logic [2:0] error_kind,
	input wire logic       text_done,
	input wire logic       text_valid
);

	logic out_take;
	logic err_open_q;

	assign out_take = out_valid && !out_stall;

	// track a text whose failure has already been reported
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_open_q <= 1'b0;
		end else if (out_take) begin
			if (text_done) begin
				err_open_q <= 1'b0;
			end else if (error_kind != ERR_NONE) begin
				err_open_q <= 1'b1;
			end
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(byte_ok) && $stable(error_kind)
			&& $stable(text_done) && $stable(text_valid))
		else $error("stalled result changed");

	a_after_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && err_open_q |-> !byte_ok && error_kind == ERR_NONE && !text_valid)
		else $error("byte after a failure was checked or accepted");

	a_text_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && text_valid |-> text_done && byte_ok && error_kind == ERR_NONE)
		else $error("valid text flagged on a failing or non-final result");

	a_truncated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_kind == ERR_TRUNCATED |-> text_done && !byte_ok)
		else $error("truncation reported away from text end");

endmodule

bind utf8_stream_validator_unit u8sv_checker u_u8sv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.byte_ok    (byte_ok),
	.error_kind (error_kind),
	.text_done  (text_done),
	.text_valid (text_valid)
);

`default_nettype wire

// File: tb/sv/utf8_stream_validator_unit_test.sv
// Self-checking testbench for the streaming UTF-8 validator top level.
module utf8_stream_validator_unit_test;
	import u8sv_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Quiet cycles allowed with no request moving on either side before giving up.
	// The worst gaps come from 82 % random idling, so this is far beyond any
	// plausible run of idle or stalled cycles.
	localparam int WATCHDOG_LIMIT = 2000;
	// Cycles to hold after the last result: two-stage pipeline plus margin.
	localparam int DRAIN_CYCLES   = 8;

	// Pacing of the two sides, carried with each byte so that the change of
	// pacing lands exactly where that byte is offered to the block.
	typedef enum logic [1:0] {
		PACE_SINK_BUSY,
		PACE_SOURCE_BUSY,
		PACE_FREE_RUN
	} pace_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		pace_t      pace;
	} byte_req_t;

	typedef struct packed {
		logic      ok;
		err_kind_t kind;
		logic      done;
		logic      valid;
	} verdict_t;

	logic       clk;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic [7:0] data_byte  = 8'h00;
	logic       last_byte  = 1'b0;
	logic       out_stall  = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic       byte_ok;
	logic [2:0] error_kind;
	logic       text_done;
	logic       text_valid;

	wire in_fire  = in_valid && !in_stall;
	wire out_fire = out_valid && !out_stall;

	// Bytes waiting to be offered, and verdicts owed by the block in order.
	byte_req_t  pending_bytes[$];
	verdict_t   expected_verdicts[$];
	logic [7:0] text_buf[$];

	int send_gap_pct = 0;
	int stall_pct    = 0;
	int quiet_cycles = 0;
	int mismatches   = 0;
	int bytes_sent   = 0;
	int texts_closed = 0;
	int texts_passed = 0;
	int kind_seen[0:4];

	// Predictor state: one sequence in flight, reset at every text end.
	logic [1:0] owed_conts;
	logic [7:0] low_bound;
	logic [7:0] high_bound;
	logic       text_failed;

	utf8_stream_validator_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.byte_ok    (byte_ok),
		.error_kind (error_kind),
		.text_done  (text_done),
		.text_valid (text_valid)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void clear_sequence();
		owed_conts  = 2'd0;
		low_bound   = CONT_LOW;
		high_bound  = CONT_HIGH;
		text_failed = 1'b0;
	endfunction

	// Judge one byte against the sequence in flight and advance it.
	// A failing byte leaves the sequence untouched.
	function automatic err_kind_t classify_byte(input logic [7:0] b);
		if (owed_conts != 2'd0) begin
			if (b < low_bound || b > high_bound)
				return ERR_BAD_CONT;
			owed_conts = owed_conts - 2'd1;
			low_bound  = CONT_LOW;
			high_bound = CONT_HIGH;
			return ERR_NONE;
		end
		if (b == 8'h00)
			return ERR_ZERO;
		if (b <= ASCII_HIGH)
			return ERR_NONE;
		if (b >= LEAD2_LOW && b <= LEAD2_HIGH) begin
			owed_conts = 2'd1;
		end else if (b == LEAD_E0) begin
			owed_conts = 2'd2;
			low_bound  = E0_CONT_LOW;
		end else if ((b >= LEAD3_LOW && b <= LEAD3_MID_HIGH) ||
				(b > LEAD_ED && b <= LEAD3_HIGH)) begin
			owed_conts = 2'd2;
		end else if (b == LEAD_ED) begin
			owed_conts = 2'd2;
			high_bound = ED_CONT_HIGH;
		end else if (b == LEAD_F0) begin
			owed_conts = 2'd3;
			low_bound  = F0_CONT_LOW;
		end else if (b >= LEAD4_LOW && b <= LEAD4_HIGH) begin
			owed_conts = 2'd3;
		end else if (b == LEAD_F4) begin
			owed_conts = 2'd3;
			high_bound = F4_CONT_HIGH;
		end else begin
			return ERR_BAD_LEAD;
		end
		return ERR_NONE;
	endfunction

	function automatic verdict_t predict_verdict(input byte_req_t req);
		verdict_t  v;
		err_kind_t k;
		v = '0;
		k = ERR_NONE;
		// Once a text has failed, later bytes are not judged at all.
		if (!text_failed) begin
			k = classify_byte(req.data);
			if (k == ERR_NONE && req.last && owed_conts != 2'd0)
				k = ERR_TRUNCATED;
			if (k != ERR_NONE)
				text_failed = 1'b1;
			else
				v.ok = 1'b1;
		end
		v.kind  = k;
		v.done  = req.last;
		v.valid = req.last && !text_failed;
		if (req.last)
			clear_sequence();
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------

	// Favour the ends of a range: that is where the bound checks live.
	function automatic logic [7:0] pick_in(input logic [7:0] lo, input logic [7:0] hi);
		case ($urandom_range(0, 3))
			0:       return lo;
			1:       return hi;
			default: return 8'($urandom_range(lo, hi));
		endcase
	endfunction

	// Append one well-formed character of random length to the text.
	task automatic add_char();
		logic [7:0] lead;
		logic [7:0] lo;
		logic [7:0] hi;
		case ($urandom_range(0, 3))
			0: begin
				text_buf.push_back(pick_in(8'h01, ASCII_HIGH));
			end
			1: begin
				text_buf.push_back(pick_in(LEAD2_LOW, LEAD2_HIGH));
				text_buf.push_back(pick_in(CONT_LOW, CONT_HIGH));
			end
			2: begin
				lead = 8'($urandom_range(LEAD_E0, LEAD3_HIGH));
				lo   = (lead == LEAD_E0) ? E0_CONT_LOW : CONT_LOW;
				hi   = (lead == LEAD_ED) ? ED_CONT_HIGH : CONT_HIGH;
				text_buf.push_back(lead);
				text_buf.push_back(pick_in(lo, hi));
				text_buf.push_back(pick_in(CONT_LOW, CONT_HIGH));
			end
			default: begin
				lead = 8'($urandom_range(LEAD_F0, LEAD_F4));
				lo   = (lead == LEAD_F0) ? F0_CONT_LOW : CONT_LOW;
				hi   = (lead == LEAD_F4) ? F4_CONT_HIGH : CONT_HIGH;
				text_buf.push_back(lead);
				text_buf.push_back(pick_in(lo, hi));
				text_buf.push_back(pick_in(CONT_LOW, CONT_HIGH));
				text_buf.push_back(pick_in(CONT_LOW, CONT_HIGH));
			end
		endcase
	endtask

	// Move the built text into the request queue, flagging its final byte.
	task automatic queue_text(input pace_t pace);
		byte_req_t req;
		for (int i = 0; i < text_buf.size(); i++) begin
			req.data = text_buf[i];
			req.last = (i == text_buf.size() - 1);
			req.pace = pace;
			pending_bytes.push_back(req);
		end
	endtask

	// Directed text of up to four bytes, most significant byte first.
	task automatic queue_literal_text(input logic [31:0] bytes, input int n);
		text_buf.delete();
		for (int i = n - 1; i >= 0; i--)
			text_buf.push_back(bytes[8*i +: 8]);
		queue_text(PACE_SINK_BUSY);
	endtask

	// Mostly well-formed texts with random content; the rest broken or noise.
	task automatic make_text(input pace_t pace);
		int style;
		int pos;
		text_buf.delete();
		style = $urandom_range(0, 99);
		if (style < 10) begin
			repeat ($urandom_range(1, 6))
				text_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 5))
				add_char();
			if (style >= 72) begin
				pos = $urandom_range(0, text_buf.size() - 1);
				case ($urandom_range(0, 3))
					0: text_buf[pos] = 8'($urandom_range(0, 255));
					1: text_buf[pos] = 8'h00;
					2: if (text_buf.size() > 1) void'(text_buf.pop_back());
					default: text_buf.push_back(pick_in(CONT_LOW, CONT_HIGH));
				endcase
			end
		end
		queue_text(pace);
	endtask

	task automatic fill_phase(input pace_t pace, input int upto);
		while (pending_bytes.size() < upto)
			make_text(pace);
	endtask

	// ------------------------------------------------------------------
	// Driver: offer one byte request at a time, hold it while stalled
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin : byte_driver
		byte_req_t req;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			data_byte <= 8'h00;
			last_byte <= 1'b0;
		end else begin
			// Predict at the moment the block takes the byte.
			if (in_fire) begin
				req.data = data_byte;
				req.last = last_byte;
				req.pace = PACE_FREE_RUN;
				expected_verdicts.push_back(predict_verdict(req));
				bytes_sent++;
			end
			// Advance only when the slot is free; a stalled request holds.
			if (!in_valid || !in_stall) begin
				if (pending_bytes.size() != 0 &&
						$urandom_range(0, 99) >= send_gap_pct) begin
					req = pending_bytes.pop_front();
					data_byte <= req.data;
					last_byte <= req.last;
					in_valid  <= 1'b1;
					case (req.pace)
						PACE_SINK_BUSY: begin
							send_gap_pct <= 12;
							stall_pct    <= 82;
						end
						PACE_SOURCE_BUSY: begin
							send_gap_pct <= 82;
							stall_pct    <= 12;
						end
						default: begin
							send_gap_pct <= 0;
							stall_pct    <= 0;
						end
					endcase
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare each result request with the oldest prediction
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin : result_monitor
		verdict_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_fire) begin
				if (expected_verdicts.size() == 0) begin
					$error("result with no byte outstanding: byte_ok %0d error_kind %0d",
						byte_ok, error_kind);
					mismatches++;
				end else begin
					want = expected_verdicts.pop_front();
					if (byte_ok !== want.ok) begin
						$error("byte_ok: expected %0d, got %0d", want.ok, byte_ok);
						mismatches++;
					end
					if (error_kind !== want.kind) begin
						$error("error_kind: expected %0d, got %0d", want.kind, error_kind);
						mismatches++;
					end
					if (text_done !== want.done) begin
						$error("text_done: expected %0d, got %0d", want.done, text_done);
						mismatches++;
					end
					if (text_valid !== want.valid) begin
						$error("text_valid: expected %0d, got %0d", want.valid, text_valid);
						mismatches++;
					end
					kind_seen[want.kind]++;
					if (want.done)
						texts_closed++;
					if (want.valid)
						texts_passed++;
				end
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: count cycles in which neither side moves a request
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= (in_fire || out_fire) ? 0 : quiet_cycles + 1;
	end

	initial begin : watchdog
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$error("no request moved for %0d cycles, %0d results outstanding",
			WATCHDOG_LIMIT, expected_verdicts.size());
		$display("FAILED: results differ");
		$finish;
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin : stimulus
		for (int i = 0; i <= 4; i++)
			kind_seen[i] = 0;
		clear_sequence();

		// Directed texts: field extremes, most lead classes and each error path.
		queue_literal_text(32'h00, 1);          // zero byte where a lead is due
		queue_literal_text(32'h7F01, 2);        // ASCII extremes
		queue_literal_text(32'hDFBF, 2);        // top two-byte form
		queue_literal_text(32'hE0A0BF, 3);      // E0 lead with its lowest non-overlong continuation
		queue_literal_text(32'hEDA041, 3);      // surrogate, then an ignored byte
		queue_literal_text(32'hF48F80BF, 4);    // F4 lead with its highest allowed continuation
		queue_literal_text(32'hF08F, 2);        // overlong four-byte form
		queue_literal_text(32'hFF, 1);          // never a lead
		queue_literal_text(32'hC1, 1);          // overlong two-byte lead
		queue_literal_text(32'hE180, 2);        // text ends mid-sequence
		queue_literal_text(32'hC200, 2);        // zero byte where a continuation is owed
		queue_literal_text(32'h80, 1);          // stray continuation

		// Random texts over three pacing phases.
		fill_phase(PACE_SINK_BUSY, 550);
		fill_phase(PACE_SOURCE_BUSY, 1100);
		fill_phase(PACE_FREE_RUN, 1650);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: everything offered, taken and answered.
		while (pending_bytes.size() != 0 || in_valid || expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d bytes in %0d texts, %0d of them valid UTF-8.",
			bytes_sent, texts_closed, texts_passed);
		$display("Failures seen: bad lead %0d, bad continuation %0d, zero %0d, truncated %0d.",
			kind_seen[ERR_BAD_LEAD], kind_seen[ERR_BAD_CONT], kind_seen[ERR_ZERO],
			kind_seen[ERR_TRUNCATED]);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
